/* design/assert_macros.svh */
// assert_macros.svh: assertion shorthands for the watchpoint unit.
// No dependencies; expects clk and rst_n in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define MWU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent in this cycle implies consequent in the next.
`define MWU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* design/mwu_pkg.sv */
// mwu_pkg: types, codes and the alias mask of the watchpoint unit.
// No dependencies; used by the interface users, mwu_cell and the top level.
package mwu_pkg;

  // operation codes
  localparam logic [2:0] OP_CHECK     = 3'd0;
  localparam logic [2:0] OP_ADD       = 3'd1;
  localparam logic [2:0] OP_REMOVE    = 3'd2;
  localparam logic [2:0] OP_CHANGE    = 3'd3;
  localparam logic [2:0] OP_SET_COND  = 3'd4;
  localparam logic [2:0] OP_CLR_COND  = 3'd5;
  localparam logic [2:0] OP_CLEAR_ALL = 3'd6;

  // result status codes
  localparam logic [1:0] STATUS_DONE      = 2'd0;
  localparam logic [1:0] STATUS_NO_ACTION = 2'd1;
  localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;
  localparam logic [1:0] STATUS_FULL      = 2'd3;

  // kind and action bit positions
  localparam int KB_READ   = 0;
  localparam int KB_WRITE  = 1;
  localparam int KB_CHANGE = 2;
  localparam int AB_PAUSE  = 1;

  // cell commands
  localparam logic [2:0] CELL_NOP   = 3'd0;
  localparam logic [2:0] CELL_LOAD  = 3'd1;
  localparam logic [2:0] CELL_MERGE = 3'd2;
  localparam logic [2:0] CELL_SETKA = 3'd3;
  localparam logic [2:0] CELL_COND  = 3'd4;
  localparam logic [2:0] CELL_HITS  = 3'd5;
  localparam logic [2:0] CELL_SHIFT = 3'd6;

  // alias masking constants
  localparam logic [31:0] ALIAS_SEL_MASK = 32'h3F80_0000;
  localparam logic [31:0] ALIAS_VRAM     = 32'h0400_0000;
  localparam logic [31:0] VRAM_CLR       = 32'h4060_0000;
  localparam logic [31:0] MIRROR_CLR     = 32'hC000_0000;

  localparam int IDX_OUT_W = 4;

  typedef struct packed {
    logic [2:0]  operation;
    logic [31:0] access_address;
    logic [31:0] access_size;
    logic        is_write;
    logic        value_changes;
    logic        condition_passed;
    logic [31:0] range_start;
    logic [31:0] range_end;
    logic [2:0]  watch_kinds;
    logic [1:0]  action_bits;
  } in_item_t;

  typedef struct packed {
    logic [1:0]           status;
    logic [IDX_OUT_W-1:0] entry_index;
    logic [1:0]           fired_actions;
    logic [31:0]          hit_total;
    logic [31:0]          matched_start;
  } out_item_t;

  typedef struct packed {
    logic [31:0] start_addr;
    logic [31:0] end_addr;
    logic [2:0]  kinds;
    logic [1:0]  actions;
    logic        has_cond;
    logic [31:0] hits;
  } entry_t;

  // command broadcast to every cell; each cell acts only when selected
  typedef struct packed {
    logic [2:0] op;
    entry_t     ent;
  } cell_cmd_t;

  // lookup request broadcast to every cell
  typedef struct packed {
    logic [31:0] key_start;
    logic [31:0] key_end;
    logic [31:0] acc_lo;   // masked access address
    logic [31:0] acc_hi;   // masked access end
  } match_req_t;

  function automatic logic [31:0] alias_mask(input logic [31:0] v);
    if ((v & ALIAS_SEL_MASK) == ALIAS_VRAM) begin
      return v & ~VRAM_CLR;
    end
    return v & ~MIRROR_CLR;
  endfunction

endpackage

/* design/mwu_stream_if.sv */
// mwu_stream_if: valid/ready channel carrying one payload item.
// No dependencies; payload type set at instantiation.
interface mwu_stream_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

/* design/memory_watchpoint_unit.sv */
// memory_watchpoint_unit: ordered watchpoint table with range compare.
// Depends on mwu_pkg, mwu_stream_if, mwu_cell and assert_macros.svh.
//
// Channels: in_ch takes one operation per transfer (check access, add,
// remove, change, set/clear condition, clear all); out_ch returns exactly
// one result per operation, in order. Both use valid/ready.
// Each table slot is an mwu_cell; all cells compare the request in
// parallel, and a remove makes the removed slot and the cells above it copy
// their upper neighbor so the table stays packed.
// Timing: an operation is taken in IDLE, the cells compare it (MATCH),
// the first matching slot is picked (SELECT) and the update plus result
// register load happen in APPLY. out_ch.valid is registered in APPLY; a
// new item is taken only once the previous one has left APPLY, as set by the
// four-step sequencer around the cell row.
// Stall: a finished result sits in the output register; the next item
// is still taken and compared, and only its APPLY step waits for out_ch
// to drain.
// Reset (rst_n low, synchronous): empty table, output register empty,
// in_ch held not ready. Slot contents are not cleared; only slots below
// the count are read.
`include "assert_macros.svh"

module memory_watchpoint_unit #(
  parameter int TABLE_ENTRIES = 16
) (
  input logic        clk,
  input logic        rst_n,
  mwu_stream_if.sink   in_ch,
  mwu_stream_if.source out_ch
);
  import mwu_pkg::*;

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TABLE_ENTRIES);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_MATCH  = 2'd1;
  localparam logic [1:0] ST_SELECT = 2'd2;
  localparam logic [1:0] ST_APPLY  = 2'd3;

  // sequencer and table fill
  logic [1:0]       state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  // captured request (payload, no reset)
  in_item_t    req_r;
  match_req_t  mreq_r;

  // per-cell lookup flags and selection
  logic [TABLE_ENTRIES-1:0] key_v, acc_v, valid_v;
  logic [TABLE_ENTRIES-1:0] flags_r, first_oh;
  entry_t                   ent_q [TABLE_ENTRIES];
  entry_t                   sel_ent;
  logic [IDX_W-1:0]         sel_idx;
  logic [IDX_W-1:0]         sel_idx_r;
  logic                     sel_found_r;
  entry_t                   sel_ent_r;

  // APPLY step
  logic                     advance;
  cell_cmd_t                cmd;
  logic [TABLE_ENTRIES-1:0] cell_sel;
  out_item_t                res;
  logic                     hit;
  logic [31:0]              hits_inc;

  // output register
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r;

  assign in_ch.ready  = rst_n && (state_r == ST_IDLE);
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  // APPLY may proceed once the output register is free or draining
  assign advance = !out_valid_r || out_ch.ready;

  // ---------------------------------------------------------------- cells
  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    assign valid_v[i] = CNT_W'(i) < count_r;
    mwu_cell u_cell (
      .clk     (clk),
      .cmd     (cmd),
      .sel     (cell_sel[i]),
      .valid   (valid_v[i]),
      .nbr     (ent_q[(i + 1 < TABLE_ENTRIES) ? i + 1 : i]),
      .req     (mreq_r),
      .ent     (ent_q[i]),
      .key_hit (key_v[i]),
      .acc_hit (acc_v[i])
    );
  end

  // ------------------------------------------------------ first-match pick
  // lowest set flag isolated by a two's complement and
  assign first_oh = flags_r & (~flags_r + TABLE_ENTRIES'(1));

  always_comb begin
    sel_idx = '0;
    sel_ent = '0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (first_oh[i]) begin
        sel_idx = sel_idx | IDX_W'(i);
        sel_ent = sel_ent | ent_q[i];
      end
    end
  end

  // ------------------------------------------------------------ APPLY logic
  assign hits_inc = (sel_ent_r.hits == '1) ? sel_ent_r.hits : sel_ent_r.hits + 32'd1;

  always_comb begin
    logic rw_ok;
    logic apply_ok;
    rw_ok    = req_r.is_write ? sel_ent_r.kinds[KB_WRITE] : sel_ent_r.kinds[KB_READ];
    apply_ok = !(req_r.is_write && sel_ent_r.kinds[KB_WRITE] && sel_ent_r.kinds[KB_CHANGE])
               || req_r.value_changes;
    hit = sel_found_r && apply_ok && rw_ok && (!sel_ent_r.has_cond || req_r.condition_passed);

    res                = '0;
    res.status         = STATUS_NO_ACTION;
    cmd.op             = CELL_NOP;
    cmd.ent.start_addr = req_r.range_start;
    cmd.ent.end_addr   = req_r.range_end;
    cmd.ent.kinds      = req_r.watch_kinds;
    cmd.ent.actions    = req_r.action_bits;
    cmd.ent.has_cond   = (req_r.operation == OP_SET_COND);
    cmd.ent.hits       = '0;
    cell_sel           = '0;
    count_nxt          = count_r;

    case (req_r.operation)
      OP_CHECK: begin
        if (sel_found_r) begin
          res.entry_index = IDX_OUT_W'(sel_idx_r);
          res.hit_total   = hit ? hits_inc : sel_ent_r.hits;
          if (hit) begin
            res.status        = STATUS_DONE;
            res.fired_actions = sel_ent_r.actions;
            res.matched_start = sel_ent_r.actions[AB_PAUSE] ? sel_ent_r.start_addr : '0;
            cmd.op            = CELL_HITS;
            cmd.ent.hits      = hits_inc;
            cell_sel          = first_oh;
          end
        end
      end
      OP_ADD: begin
        if (sel_found_r) begin
          res.status      = STATUS_DONE;
          res.entry_index = IDX_OUT_W'(sel_idx_r);
          cmd.op          = CELL_MERGE;
          cell_sel        = first_oh;
        end else if (count_r == FULL_CNT) begin
          res.status = STATUS_FULL;
        end else begin
          res.status      = STATUS_DONE;
          res.entry_index = IDX_OUT_W'(count_r);
          cmd.op          = CELL_LOAD;
          for (int i = 0; i < TABLE_ENTRIES; i++) begin
            cell_sel[i] = (CNT_W'(i) == count_r);
          end
          count_nxt = count_r + CNT_W'(1);
        end
      end
      OP_REMOVE, OP_CHANGE, OP_SET_COND, OP_CLR_COND: begin
        if (!sel_found_r) begin
          res.status = STATUS_NOT_FOUND;
        end else begin
          res.status      = STATUS_DONE;
          res.entry_index = IDX_OUT_W'(sel_idx_r);
          if (req_r.operation == OP_REMOVE) begin
            cmd.op = CELL_SHIFT;
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
              cell_sel[i] = (IDX_W'(i) >= sel_idx_r);
            end
            count_nxt = count_r - CNT_W'(1);
          end else if (req_r.operation == OP_CHANGE) begin
            cmd.op   = CELL_SETKA;
            cell_sel = first_oh;
          end else begin
            cmd.op   = CELL_COND;
            cell_sel = first_oh;
          end
        end
      end
      OP_CLEAR_ALL: begin
        res.status = STATUS_DONE;
        count_nxt  = '0;
      end
      default: begin
        res.status = STATUS_NO_ACTION;
      end
    endcase

    // nothing is written outside a committing APPLY cycle
    if (!(state_r == ST_APPLY && advance)) begin
      cmd.op    = CELL_NOP;
      cell_sel  = '0;
      count_nxt = count_r;
    end
  end

  // ------------------------------------------------------------- sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (in_ch.valid) state_nxt = ST_MATCH;
      ST_MATCH:  state_nxt = ST_SELECT;
      ST_SELECT: state_nxt = ST_APPLY;
      ST_APPLY:  if (advance) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ch.ready;
    if (state_r == ST_APPLY && advance) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_ch.valid) begin
      req_r            <= in_ch.data;
      mreq_r.key_start <= in_ch.data.range_start;
      mreq_r.key_end   <= in_ch.data.range_end;
      mreq_r.acc_lo    <= alias_mask(in_ch.data.access_address);
      mreq_r.acc_hi    <= alias_mask(in_ch.data.access_address + in_ch.data.access_size);
    end
    if (state_r == ST_MATCH) begin
      flags_r <= (req_r.operation == OP_CHECK) ? acc_v : key_v;
    end
    if (state_r == ST_SELECT) begin
      sel_idx_r   <= sel_idx;
      sel_found_r <= |flags_r;
      sel_ent_r   <= sel_ent;
    end
    if (state_r == ST_APPLY && advance) begin
      out_data_r <= res;
    end
  end

  // ------------------------------------------------------------ assertions
  `MWU_ASSERT(a_count_bound, count_r <= FULL_CNT, "entry count beyond table size")
  `MWU_ASSERT_NEXT(a_full_holds, state_r == ST_APPLY && req_r.operation == OP_ADD && !sel_found_r && count_r == FULL_CNT, count_r == FULL_CNT, "add to full table changed count")
  `MWU_ASSERT_NEXT(a_remove_dec, state_r == ST_APPLY && advance && req_r.operation == OP_REMOVE && sel_found_r, count_r == $past(count_r) - CNT_W'(1), "remove did not shrink table")
  `MWU_ASSERT_NEXT(a_result_src, !out_valid_r && !(state_r == ST_APPLY), !out_valid_r, "result appeared without an apply step")

endmodule

/* design/mwu_cell.sv */
// mwu_cell: one watchpoint table slot with its own key and access compare.
// Depends on mwu_pkg.
module mwu_cell (
  input  logic                clk,
  input  mwu_pkg::cell_cmd_t  cmd,
  input  logic                sel,
  input  logic                valid,
  input  mwu_pkg::entry_t     nbr,
  input  mwu_pkg::match_req_t req,
  output mwu_pkg::entry_t     ent,
  output logic                key_hit,
  output logic                acc_hit
);
  import mwu_pkg::*;

  entry_t      ent_r, ent_nxt;
  logic [31:0] m_start, m_end;

  always_comb begin
    ent_nxt = ent_r;
    if (sel) begin
      case (cmd.op)
        CELL_LOAD:  ent_nxt = cmd.ent;
        CELL_MERGE: begin
          ent_nxt.kinds   = ent_r.kinds | cmd.ent.kinds;
          ent_nxt.actions = ent_r.actions | cmd.ent.actions;
        end
        CELL_SETKA: begin
          ent_nxt.kinds   = cmd.ent.kinds;
          ent_nxt.actions = cmd.ent.actions;
        end
        CELL_COND:  ent_nxt.has_cond = cmd.ent.has_cond;
        CELL_HITS:  ent_nxt.hits = cmd.ent.hits;
        CELL_SHIFT: ent_nxt = nbr;   // take the neighbor above
        default:    ent_nxt = ent_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

  assign ent = ent_r;

  // exact key compare, unmasked
  assign key_hit = valid && (ent_r.start_addr == req.key_start) &&
                   (ent_r.end_addr == req.key_end);

  // access compare after alias masking; zero end means single address
  assign m_start = alias_mask(ent_r.start_addr);
  assign m_end   = alias_mask(ent_r.end_addr);
  always_comb begin
    if (ent_r.end_addr != 32'd0) begin
      acc_hit = valid && (req.acc_hi > m_start) && (req.acc_lo < m_end);
    end else begin
      acc_hit = valid && (m_start == req.acc_lo);
    end
  end

endmodule
